// File: rtl/sppq_pkg.sv
package sppq_pkg;

	localparam int DEPTH_DEF = 16;

	typedef enum logic [0:0] {
		OP_ENQ = 1'b0,
		OP_DEQ = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// one stored packet record
	typedef struct packed {
		logic [3:0]  prio;
		logic [15:0] arrival_time;
		logic [3:0]  switch_id;
		logic [15:0] tx_time;
		logic [15:0] tx_start;
	} entry_t;

	typedef struct packed {
		logic [0:0]  opcode;
		logic [3:0]  prio;
		logic [15:0] arrival_time;
		logic [3:0]  switch_id;
		logic [15:0] tx_time;
		logic [15:0] tx_start;
	} req_t;

	typedef struct packed {
		logic        out_valid;
		logic [3:0]  out_prio;
		logic [15:0] out_arrival;
		logic [3:0]  out_switch;
		logic [15:0] out_tx_time;
		logic [15:0] out_tx_start;
		logic [1:0]  status;
		logic [4:0]  occupancy;
	} rsp_t;

	// per-cycle command broadcast to every cell
	typedef struct packed {
		logic enq;
		logic deq;
	} cell_ctl_t;

endpackage

// File: rtl/sppq_chan_if.sv
interface sppq_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/sppq_cell.sv
module sppq_cell (
	input  logic               clk,
	input  sppq_pkg::cell_ctl_t ctl,
	input  logic               occupied,
	input  sppq_pkg::entry_t   new_entry,
	input  logic               prev_ins,
	input  sppq_pkg::entry_t   prev_entry,
	input  sppq_pkg::entry_t   next_entry,
	output logic               ins,
	output sppq_pkg::entry_t   entry
);
	import sppq_pkg::*;

	entry_t entry_q;

	// free slot, or a stored packet of strictly lower priority: shifts down on insert
	assign ins   = !occupied || (entry_q.prio < new_entry.prio);
	assign entry = entry_q;

	// take the new packet at the insert point, shift behind it, advance on removal
	always_ff @(posedge clk) begin
		if (ctl.enq) begin
			if (ins) begin
				entry_q <= prev_ins ? prev_entry : new_entry;
			end
		end else if (ctl.deq) begin
			entry_q <= next_entry;
		end
	end
endmodule

// File: rtl/stable_priority_packet_queue_core.sv
// Stable priority packet queue. Holds up to Depth packets ordered by descending
// priority, first-in first-out among equal priorities, in a row of cells that
// each compare against an incoming packet and shift toward the tail on insert
// or toward the head on removal. Every request (enqueue or dequeue) yields
// exactly one response; a new request is accepted each cycle as long as the
// single response register is empty or being drained at that edge. An enqueue
// into a full queue is dropped with status 2; a dequeue on an empty queue
// returns zero fields with status 1. Occupancy reports the entry count after
// the request, truncated to five bits. No clearing pass is needed after reset.
module stable_priority_packet_queue_core #(
	parameter int Depth = sppq_pkg::DEPTH_DEF
) (
	input logic      clk,
	input logic      arst_n,
	sppq_chan_if.sink   in_ch,
	sppq_chan_if.source out_ch
);
	import sppq_pkg::*;

	localparam int CW = $clog2(Depth + 1);

	logic [CW-1:0] count_q;
	logic          rsp_vld_q;
	rsp_t          rsp_q;
	req_t          req;
	logic          acc;
	logic          is_deq;
	logic          full;
	logic          empty;
	cell_ctl_t     ctl;
	entry_t        new_entry;
	entry_t        ent [Depth];
	logic          ins [Depth];
	logic [CW+4:0] cnt_ext;
	logic [CW-1:0] count_nxt;
	rsp_t          rsp_nxt;

	assign req    = in_ch.payload;
	assign in_ch.ready = !rsp_vld_q || out_ch.ready;
	assign acc    = in_ch.valid && in_ch.ready;
	assign is_deq = (req.opcode == OP_DEQ);
	assign full   = (count_q == CW'(Depth));
	assign empty  = (count_q == '0);

	assign ctl.enq = acc && !is_deq && !full;
	assign ctl.deq = acc && is_deq && !empty;

	assign new_entry = '{prio: req.prio, arrival_time: req.arrival_time,
		switch_id: req.switch_id, tx_time: req.tx_time, tx_start: req.tx_start};

	// row of cells; the head is cell 0
	for (genvar i = 0; i < Depth; i++) begin : g_cell
		logic   occ;
		logic   p_ins;
		entry_t p_ent;
		entry_t n_ent;

		assign occ = (count_q > CW'(i));
		if (i == 0) begin : g_head
			assign p_ins = 1'b0;
			assign p_ent = new_entry;
		end else begin : g_body
			assign p_ins = ins[i-1];
			assign p_ent = ent[i-1];
		end
		if (i == Depth - 1) begin : g_tail
			assign n_ent = ent[i];
		end else begin : g_mid
			assign n_ent = ent[i+1];
		end

		sppq_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.occupied   (occ),
			.new_entry  (new_entry),
			.prev_ins   (p_ins),
			.prev_entry (p_ent),
			.next_entry (n_ent),
			.ins        (ins[i]),
			.entry      (ent[i])
		);
	end

	// next count and response
	always_comb begin
		count_nxt = count_q;
		if (ctl.enq) begin
			count_nxt = count_q + CW'(1);
		end else if (ctl.deq) begin
			count_nxt = count_q - CW'(1);
		end
		cnt_ext = {5'b0, count_nxt};
		rsp_nxt = '0;
		rsp_nxt.occupancy = cnt_ext[4:0];
		if (is_deq) begin
			if (empty) begin
				rsp_nxt.status = ST_EMPTY;
			end else begin
				rsp_nxt.out_valid    = 1'b1;
				rsp_nxt.out_prio     = ent[0].prio;
				rsp_nxt.out_arrival  = ent[0].arrival_time;
				rsp_nxt.out_switch   = ent[0].switch_id;
				rsp_nxt.out_tx_time  = ent[0].tx_time;
				rsp_nxt.out_tx_start = ent[0].tx_start;
				rsp_nxt.status       = ST_OK;
			end
		end else begin
			rsp_nxt.status = full ? ST_FULL : ST_OK;
		end
	end

	// hold count and the response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			rsp_vld_q <= 1'b0;
		end else begin
			count_q <= count_nxt;
			if (acc) begin
				rsp_vld_q <= 1'b1;
			end else if (out_ch.ready) begin
				rsp_vld_q <= 1'b0;
			end
		end
	end

	// load the response register
	always_ff @(posedge clk) begin
		if (acc) begin
			rsp_q <= rsp_nxt;
		end
	end

	assign out_ch.valid   = rsp_vld_q;
	assign out_ch.payload = rsp_q;

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(Depth))
		else $error("entry count beyond depth");

	a_deq_dec: assert property (@(posedge clk) disable iff (!arst_n)
		acc && is_deq && !empty |=> count_q == $past(count_q) - CW'(1))
		else $error("dequeue did not remove one entry");

	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		acc && !is_deq && full |=> rsp_q.status == ST_FULL && count_q == CW'(Depth))
		else $error("enqueue into full queue not dropped");
`endif
endmodule

// File: verif/tb_stable_priority_packet_queue_core.sv
module tb_stable_priority_packet_queue_core;
	import sppq_pkg::*;

	localparam int PKT_DEPTH    = DEPTH_DEF;
	localparam int RANDOM_REQS  = 650;
	localparam int CALM_REQS    = 100;
	localparam int PHASE_REQS   = 30;
	localparam int HOLD_AT_REQ  = 100;
	localparam int LONG_HOLD    = 150;
	localparam int DRAIN_CYCLES = 20;
	localparam int CYCLE_LIMIT  = 400000;

	localparam req_t DEQ_REQ = '{OP_DEQ, 4'd0, 16'd0, 4'd0, 16'd0, 16'd0};

	// one directed request, with its response typed in when fixed is set
	typedef struct {
		req_t req;
		bit   fixed;
		rsp_t rsp;
	} stim_row_t;

	logic clk;
	logic arst_n;

	sppq_chan_if #(.payload_t(req_t)) req_ch ();
	sppq_chan_if #(.payload_t(rsp_t)) rsp_ch ();

	stable_priority_packet_queue_core #(.Depth(PKT_DEPTH)) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.in_ch (req_ch),
		.out_ch(rsp_ch)
	);

	// queue contents as the block should hold them, head first
	entry_t held_pkts[$];
	rsp_t   expected_rsps[$];

	int error_count      = 0;
	int reqs_sent        = 0;
	int packets_returned = 0;
	int full_drops       = 0;
	int empty_deqs       = 0;
	int cycle_count      = 0;
	bit calm             = 1'b0;
	bit long_hold_req    = 1'b0;

	function automatic req_t enq_req(logic [3:0] prio, logic [15:0] arrival, logic [3:0] sw,
			logic [15:0] tx_time, logic [15:0] tx_start);
		return '{OP_ENQ, prio, arrival, sw, tx_time, tx_start};
	endfunction

	function automatic rsp_t status_rsp(status_t st, int occ);
		rsp_t rsp;
		rsp           = '0;
		rsp.status    = st;
		rsp.occupancy = 5'(occ);
		return rsp;
	endfunction

	// apply one request to the held packets and return the response it earns
	function automatic rsp_t queue_response(req_t r);
		rsp_t   rsp;
		entry_t pkt;
		int     slot;
		rsp = '0;
		if (op_t'(r.opcode) == OP_ENQ) begin
			if (held_pkts.size() >= PKT_DEPTH) begin
				rsp.status = ST_FULL;
				full_drops++;
			end else begin
				pkt  = '{r.prio, r.arrival_time, r.switch_id, r.tx_time, r.tx_start};
				// insert ahead of the first strictly lower priority
				slot = held_pkts.size();
				for (int i = 0; i < held_pkts.size(); i++) begin
					if (slot == held_pkts.size() && held_pkts[i].prio < pkt.prio)
						slot = i;
				end
				held_pkts.insert(slot, pkt);
				rsp.status = ST_OK;
			end
		end else if (held_pkts.size() == 0) begin
			rsp.status = ST_EMPTY;
			empty_deqs++;
		end else begin
			pkt              = held_pkts.pop_front();
			rsp.out_valid    = 1'b1;
			rsp.out_prio     = pkt.prio;
			rsp.out_arrival  = pkt.arrival_time;
			rsp.out_switch   = pkt.switch_id;
			rsp.out_tx_time  = pkt.tx_time;
			rsp.out_tx_start = pkt.tx_start;
			rsp.status       = ST_OK;
			packets_returned++;
		end
		rsp.occupancy = 5'(held_pkts.size());
		return rsp;
	endfunction

	function automatic void check_field(string name, longint want, longint got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			error_count++;
		end
	endfunction

	// offer one request, with an occasional gap, and log its expected response
	task automatic send_request(req_t r, bit fixed, rsp_t fixed_rsp);
		rsp_t predicted;
		if (!calm && $urandom_range(0, 3) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		req_ch.valid   <= 1'b1;
		req_ch.payload <= r;
		do @(posedge clk); while (!req_ch.ready);
		predicted = queue_response(r);
		expected_rsps.push_back(fixed ? fixed_rsp : predicted);
		reqs_sent++;
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// stop a hung run
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$error("run exceeded %0d cycles", CYCLE_LIMIT);
		$display("Some tests failed");
		$finish;
	end

	// drain responses with random stalls and one long hold
	initial begin
		rsp_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (long_hold_req) begin
				rsp_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				long_hold_req = 1'b0;
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end else begin
				rsp_ch.ready <= 1'b1;
				repeat (calm ? 1 : $urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	// compare each accepted response with the oldest expectation
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_rsps.size() == 0) begin
				$error("response with no request outstanding");
				error_count++;
			end else begin
				want = expected_rsps.pop_front();
				check_field("out_valid", want.out_valid, rsp_ch.payload.out_valid);
				check_field("out_prio", want.out_prio, rsp_ch.payload.out_prio);
				check_field("out_arrival", want.out_arrival, rsp_ch.payload.out_arrival);
				check_field("out_switch", want.out_switch, rsp_ch.payload.out_switch);
				check_field("out_tx_time", want.out_tx_time, rsp_ch.payload.out_tx_time);
				check_field("out_tx_start", want.out_tx_start, rsp_ch.payload.out_tx_start);
				check_field("status", want.status, rsp_ch.payload.status);
				check_field("occupancy", want.occupancy, rsp_ch.payload.occupancy);
			end
		end
	end

	initial begin
		stim_row_t rows[$];
		req_t      r;
		int        enq_pct;
		int        prio_lo;
		int        prio_span;

		req_ch.valid   = 1'b0;
		req_ch.payload = '0;
		arst_n         = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty dequeue, fill to full with ties and extremes, overflow, then dequeue five with one enqueue among them
		rows = '{
			'{DEQ_REQ, 1'b1, status_rsp(ST_EMPTY, 0)},
			'{enq_req(4'hf, 16'hffff, 4'hf, 16'hffff, 16'hffff), 1'b1, status_rsp(ST_OK, 1)},
			'{enq_req(4'h0, 16'h0000, 4'h0, 16'h0000, 16'h0000), 1'b1, status_rsp(ST_OK, 2)},
			'{enq_req(4'h7, 16'h1111, 4'h1, 16'h0101, 16'h0a0a), 1'b1, status_rsp(ST_OK, 3)},
			'{enq_req(4'h7, 16'h2222, 4'h2, 16'h0202, 16'h0b0b), 1'b1, status_rsp(ST_OK, 4)},
			'{enq_req(4'h3, 16'h0033, 4'h3, 16'h0303, 16'h0c0c), 1'b1, status_rsp(ST_OK, 5)},
			'{enq_req(4'hf, 16'h5a5a, 4'h5, 16'ha5a5, 16'h5a5a), 1'b1, status_rsp(ST_OK, 6)},
			'{enq_req(4'h7, 16'h3333, 4'h3, 16'h0303, 16'h0d0d), 1'b1, status_rsp(ST_OK, 7)},
			'{enq_req(4'hc, 16'h0c0c, 4'hc, 16'h1234, 16'h4321), 1'b1, status_rsp(ST_OK, 8)},
			'{enq_req(4'h1, 16'h0101, 4'h6, 16'h7777, 16'h8888), 1'b1, status_rsp(ST_OK, 9)},
			'{enq_req(4'h0, 16'h8000, 4'h8, 16'h8000, 16'h8000), 1'b1, status_rsp(ST_OK, 10)},
			'{enq_req(4'h9, 16'h0909, 4'h9, 16'h9999, 16'h0999), 1'b1, status_rsp(ST_OK, 11)},
			'{enq_req(4'h3, 16'h0034, 4'h4, 16'h0404, 16'h0e0e), 1'b1, status_rsp(ST_OK, 12)},
			'{enq_req(4'he, 16'h0e0e, 4'he, 16'heeee, 16'h00ee), 1'b1, status_rsp(ST_OK, 13)},
			'{enq_req(4'h2, 16'h0202, 4'h2, 16'h2222, 16'h0022), 1'b1, status_rsp(ST_OK, 14)},
			'{enq_req(4'h8, 16'h0808, 4'h7, 16'h8888, 16'h0088), 1'b1, status_rsp(ST_OK, 15)},
			'{enq_req(4'h7, 16'h4444, 4'h4, 16'h0404, 16'h0f0f), 1'b1, status_rsp(ST_OK, 16)},
			'{enq_req(4'ha, 16'h0a0a, 4'ha, 16'haaaa, 16'h00aa), 1'b1, status_rsp(ST_FULL, 16)},
			'{DEQ_REQ, 1'b1,
				'{1'b1, 4'hf, 16'hffff, 4'hf, 16'hffff, 16'hffff, ST_OK, 5'd15}},
			'{DEQ_REQ, 1'b0, '0},
			'{DEQ_REQ, 1'b0, '0},
			'{DEQ_REQ, 1'b0, '0},
			'{enq_req(4'hf, 16'h7fff, 4'h1, 16'h7fff, 16'h7fff), 1'b0, '0},
			'{DEQ_REQ, 1'b0, '0}
		};
		foreach (rows[i])
			send_request(rows[i].req, rows[i].fixed, rows[i].rsp);

		// random phases sweep occupancy and narrow priorities to force ties
		enq_pct   = 50;
		prio_lo   = 0;
		prio_span = 15;
		for (int n = 0; n < RANDOM_REQS; n++) begin
			if (n % PHASE_REQS == 0) begin
				case ($urandom_range(0, 3))
					0: enq_pct = 15;
					1: enq_pct = 85;
					default: enq_pct = 50;
				endcase
				case ($urandom_range(0, 3))
					0: prio_span = 0;
					1: prio_span = 1;
					2: prio_span = 3;
					default: prio_span = 15;
				endcase
				prio_lo = $urandom_range(0, 15 - prio_span);
			end
			if (n == HOLD_AT_REQ)
				long_hold_req = 1'b1;
			if (n == RANDOM_REQS - CALM_REQS)
				calm = 1'b1;
			r.opcode       = ($urandom_range(1, 100) <= enq_pct) ? OP_ENQ : OP_DEQ;
			r.prio         = 4'(prio_lo + $urandom_range(0, prio_span));
			r.arrival_time = 16'($urandom);
			r.switch_id    = 4'($urandom);
			r.tx_time      = 16'($urandom);
			r.tx_start     = 16'($urandom);
			send_request(r, 1'b0, '0);
		end
		req_ch.valid <= 1'b0;

		// let outstanding responses land, then allow a short tail
		while (expected_rsps.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d requests: %0d packets dequeued, %0d enqueues dropped when full,",
			reqs_sent, packets_returned, full_drops);
		$display("%0d dequeues on an empty queue, with random stalls and one long output hold.",
			empty_deqs);
		if (error_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
